// File: rtl/dynamic_resolution_scale_controller_macros.svh
// Assertion helpers shared by the RTL.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef DYNAMIC_RESOLUTION_SCALE_CONTROLLER_MACROS_SVH
`define DYNAMIC_RESOLUTION_SCALE_CONTROLLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DRSC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DRSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/drsc_pkg.sv
package drsc_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SCALE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SCALE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NATIVE_W   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_NATIVE_H   = 3'd7;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [15:0] RST_MIN_SCALE = 16'd16384;
  localparam logic [15:0] RST_MAX_SCALE = 16'd32768;
  localparam logic [15:0] RST_TARGET    = 16'd267;
  localparam logic [15:0] RST_SPEED     = 16'd6554;
  localparam logic [15:0] RST_THRESHOLD = 16'd6554;
  localparam logic [13:0] RST_NATIVE_W  = 14'd1920;
  localparam logic [13:0] RST_NATIVE_H  = 14'd1080;

  // Field widths
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned NAT_W   = 14;
  localparam int unsigned DIM_W   = 15;
  localparam int unsigned CNT_W   = 16;

  // Deviation arithmetic (Q.16), saturated to +/-4.0
  localparam int unsigned MAG_W     = 19;
  localparam logic [31:0] DEV_LIMIT = 32'd262144;
  localparam logic [15:0] COMMIT_STEP = 16'd328;
  localparam logic [DIM_W-1:0] MIN_DIM = 15'd64;

  // Shared multiplier and divider sizes
  // Operand A takes the widest ring sum (16-bit times over up to 256 entries),
  // operand B the 17-bit reciprocal of the ring depth
  localparam int unsigned MUL_A_W = 24;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned DIV_N_W = 32;
  localparam int unsigned DIV_D_W = 16;
  localparam int unsigned DIV_C_W = 6;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] num;
    logic [DIV_D_W-1:0] den;
    logic [DIV_C_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Render dimension from the scaled product: round up to even, then clamp
  function automatic logic [DIM_W-1:0] dim_round(input logic [DIM_W-1:0] d,
                                                 input logic [NAT_W-1:0] native);
    logic [DIM_W:0]   d1;
    logic [DIM_W-1:0] lim;
    logic [DIM_W-1:0] r;
    d1  = ({1'b0, d} + 16'd1) & ~16'd1;
    lim = {native, 1'b0};
    if (d1 < {1'b0, MIN_DIM}) begin
      r = MIN_DIM;
    end else begin
      r = d1[DIM_W-1:0];
      if (d1[DIM_W]) r = lim;
    end
    if (r > lim) r = lim;
    return r;
  endfunction

endpackage

// File: rtl/drsc_if.sv
// Input channel: one item per transfer
interface drsc_in_if;
  import drsc_pkg::*;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [TIME_W-1:0]  frame_time;
  logic [SCALE_W-1:0] scale_value;

  modport source (output valid, opcode, frame_time, scale_value, input ready);
  modport sink   (input valid, opcode, frame_time, scale_value, output ready);
endinterface

// Output channel: one result per transfer
interface drsc_out_if;
  import drsc_pkg::*;
  logic               valid;
  logic               ready;
  logic [DIM_W-1:0]   render_width;
  logic [DIM_W-1:0]   render_height;
  logic [SCALE_W-1:0] scale;
  logic [TIME_W-1:0]  avg_frame_time;
  logic               size_changed;
  logic [CNT_W-1:0]   change_count;

  modport source (output valid, render_width, render_height, scale, avg_frame_time,
                  size_changed, change_count, input ready);
  modport sink   (input valid, render_width, render_height, scale, avg_frame_time,
                  size_changed, change_count, output ready);
endinterface

// File: rtl/drsc_ring.sv
// Frame time history: single-port memory with registered read.
// Entries never written read as zero through the valid bits.
module drsc_ring #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned PW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic                        wr_en,
  input  logic [PW-1:0]               addr,
  input  logic [drsc_pkg::TIME_W-1:0] wr_data,
  output logic [drsc_pkg::TIME_W-1:0] rd_data
);
  import drsc_pkg::*;

  logic [TIME_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid;
  logic [TIME_W-1:0] mem_q;
  logic              valid_q;

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (wr_en) mem[addr] <= wr_data;
    if (rd_en) mem_q <= mem[addr];
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wr_en) valid[addr] <= 1'b1;
      if (rd_en) valid_q <= valid[addr];
    end
  end

  assign rd_data = valid_q ? mem_q : '0;

endmodule

// File: rtl/drsc_div.sv
// Restoring divider, one quotient bit per cycle.
// The numerator is left-aligned; when done is raised the quotient sits in
// the low req.steps bits of quot.
module drsc_div (
  input  logic                         clk,
  input  logic                         rst,
  input  drsc_pkg::div_req_t           req,
  output drsc_pkg::div_stat_t          stat,
  output logic [drsc_pkg::DIV_N_W-1:0] quot
);
  import drsc_pkg::*;

  logic [DIV_N_W-1:0] q;
  logic [DIV_D_W-1:0] rem;
  logic [DIV_D_W-1:0] den;
  logic [DIV_C_W-1:0] cnt;
  logic               busy;
  logic               done;
  logic [DIV_D_W:0]   rem_sh;
  logic               ge;
  logic [DIV_D_W:0]   rem_sub;

  // One trial subtraction
  always_comb begin
    rem_sh  = {rem, q[DIV_N_W-1]};
    ge      = rem_sh >= {1'b0, den};
    rem_sub = rem_sh - {1'b0, den};
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      q   <= req.num;
      rem <= '0;
      den <= req.den;
    end else if (busy) begin
      q   <= {q[DIV_N_W-2:0], ge};
      rem <= ge ? rem_sub[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_C_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quot      = q;

endmodule

// File: rtl/dynamic_resolution_scale_controller.sv
// Dynamic resolution scale controller. Each input item either records a frame
// time (opcode 0) or forces the scale (opcode 1), and gives exactly one result
// showing render size, scale, ring average, a size-changed flag and the change
// count. A recorded frame time that moves the scale passes through the ring
// update, then the ring average by a reciprocal multiply and one correcting
// compare, the bit-serial divider for the relative deviation, and one shared
// multiplier that forms the scale step and both render dimensions in turn. The
// steps end early without an adjustment (deviation within the threshold, or
// change below the commit step). A forced scale goes straight to the render
// dimensions, a frame time while disabled straight to the result. The input
// is not ready while an item is in work; a finished result waits in an output
// register, so the next item may be taken before it is collected, and a result
// not yet collected holds the following one back. Configuration is written
// through cfg_we/cfg_index/cfg_data; the user must do so only while idle, as
// the block itself does not enforce it.
`include "dynamic_resolution_scale_controller_macros.svh"
module dynamic_resolution_scale_controller #(
  parameter int unsigned HISTORY_DEPTH   = 16,
  parameter int unsigned FORCE_MIN_SCALE = 8192,
  parameter int unsigned FORCE_MAX_SCALE = 65535
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [drsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [drsc_pkg::CFG_DATA_W-1:0] cfg_data,
  drsc_in_if.sink                        in_ch,
  drsc_out_if.source                     out_ch
);
  import drsc_pkg::*;

  localparam int unsigned PW        = $clog2(HISTORY_DEPTH);
  localparam int unsigned SW        = TIME_W + PW;
  // floor(2^SW / depth): the estimate is at most one short of the average
  localparam logic [MUL_B_W-1:0] AVG_RECIP = MUL_B_W'((64'd1 << SW) / HISTORY_DEPTH);
  localparam logic [MUL_B_W-1:0] DEPTH_B   = MUL_B_W'(HISTORY_DEPTH);
  localparam logic [SW-1:0]      DEPTH_S   = SW'(HISTORY_DEPTH);
  localparam logic [SCALE_W-1:0] FMIN = SCALE_W'(FORCE_MIN_SCALE);
  localparam logic [SCALE_W-1:0] FMAX = SCALE_W'(FORCE_MAX_SCALE);
  localparam logic [PW-1:0] PTR_LAST = PW'(HISTORY_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RING, S_AVG, S_AVG_FIX, S_DEV, S_DIV_DEV, S_CHECK, S_STEP,
    S_DIM_W, S_DIM_H, S_FIN, S_DONE
  } state_t;

  // Configuration registers
  logic               enabled;
  logic [SCALE_W-1:0] min_scale;
  logic [SCALE_W-1:0] max_scale;
  logic [TIME_W-1:0]  target;
  logic [15:0]        speed;
  logic [15:0]        threshold;
  logic [NAT_W-1:0]   nat_w;
  logic [NAT_W-1:0]   nat_h;

  // Sequencer state and working registers
  state_t             state;
  logic [PW-1:0]      ptr;
  logic [SW-1:0]      ring_sum;
  logic [TIME_W-1:0]  ft_q;
  logic [TIME_W-1:0]  avg_q;
  logic [MAG_W-1:0]   mag_q;
  logic               dev_pos;
  logic [SCALE_W-1:0] cur_scale;
  logic [DIM_W-1:0]   cur_w;
  logic [DIM_W-1:0]   cur_h;
  logic [DIM_W-1:0]   w_new;
  logic [CNT_W-1:0]   change_cnt;
  logic               changed;
  logic [MUL_P_W-1:0] prod;

  // Output register
  logic               out_valid;
  logic [DIM_W-1:0]   o_w;
  logic [DIM_W-1:0]   o_h;
  logic [SCALE_W-1:0] o_scale;
  logic [TIME_W-1:0]  o_avg;
  logic               o_changed;
  logic [CNT_W-1:0]   o_cnt;

  // Combinational helpers
  logic               accept;
  logic               ring_rd;
  logic               ring_wr;
  logic [TIME_W-1:0]  ring_old;
  logic [SW-1:0]      sum_next;
  logic [TIME_W-1:0]  avg_est;
  logic [SW-1:0]      avg_rem;
  logic [TIME_W-1:0]  tgt_eff;
  logic               avg_gt;
  logic [TIME_W-1:0]  abs_diff;
  div_req_t           div_req;
  div_stat_t          div_stat;
  logic [DIV_N_W-1:0] quot;
  logic [MAG_W-1:0]   sat_mag;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [17:0]        step;
  logic signed [19:0] ns;
  logic signed [19:0] ns_lo;
  logic [SCALE_W-1:0] ns_cl;
  logic [SCALE_W-1:0] scale_diff;
  logic [SCALE_W-1:0] force_lo;
  logic [SCALE_W-1:0] force_scale;
  logic [DIM_W-1:0]   dim_cur;
  logic [DIM_W-1:0]   h_new;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled   <= 1'b1;
      min_scale <= RST_MIN_SCALE;
      max_scale <= RST_MAX_SCALE;
      target    <= RST_TARGET;
      speed     <= RST_SPEED;
      threshold <= RST_THRESHOLD;
      nat_w     <= RST_NATIVE_W;
      nat_h     <= RST_NATIVE_H;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLED:   enabled   <= cfg_data[0];
        CFG_MIN_SCALE: min_scale <= cfg_data;
        CFG_MAX_SCALE: max_scale <= cfg_data;
        CFG_TARGET:    target    <= cfg_data;
        CFG_SPEED:     speed     <= cfg_data;
        CFG_THRESHOLD: threshold <= cfg_data;
        CFG_NATIVE_W:  nat_w     <= cfg_data[NAT_W-1:0];
        CFG_NATIVE_H:  nat_h     <= cfg_data[NAT_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign ring_rd     = accept && !in_ch.opcode && enabled;
  assign ring_wr     = (state == S_RING);

  drsc_ring #(.DEPTH(HISTORY_DEPTH), .PW(PW)) u_ring (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (ring_rd),
    .wr_en   (ring_wr),
    .addr    (ptr),
    .wr_data (ft_q),
    .rd_data (ring_old)
  );

  // Running sum, average estimate and deviation operands
  always_comb begin
    sum_next = ring_sum - SW'(ring_old) + SW'(ft_q);
    avg_est  = prod[SW +: TIME_W];
    avg_rem  = ring_sum - prod[SW-1:0];
    tgt_eff  = (target == '0) ? TIME_W'(1) : target;
    avg_gt   = avg_q > tgt_eff;
    abs_diff = avg_gt ? (avg_q - tgt_eff) : (tgt_eff - avg_q);
  end

  // Divider request: deviation magnitude
  always_comb begin
    div_req.start = (state == S_DEV);
    div_req.num   = {abs_diff, 16'd0};
    div_req.den   = tgt_eff;
    div_req.steps = DIV_C_W'(DIV_N_W);
  end

  drsc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .stat (div_stat),
    .quot (quot)
  );

  assign sat_mag = (quot > DEV_LIMIT) ? MAG_W'(DEV_LIMIT) : quot[MAG_W-1:0];

  // Shared multiplier operand select
  always_comb begin
    case (state)
      S_RING: begin
        mul_a = MUL_A_W'(sum_next);
        mul_b = AVG_RECIP;
      end
      S_AVG: begin
        mul_a = MUL_A_W'(avg_est);
        mul_b = DEPTH_B;
      end
      S_CHECK: begin
        mul_a = MUL_A_W'(mag_q);
        mul_b = MUL_B_W'(speed);
      end
      S_DIM_W: begin
        mul_a = MUL_A_W'(nat_w);
        mul_b = MUL_B_W'(cur_scale);
      end
      S_DIM_H: begin
        mul_a = MUL_A_W'(nat_h);
        mul_b = MUL_B_W'(cur_scale);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // New scale from the step, clamped and checked against the commit step
  always_comb begin
    step  = prod[17 +: 18];
    ns    = dev_pos ? (signed'({4'd0, cur_scale}) - signed'({2'd0, step}))
                    : (signed'({4'd0, cur_scale}) + signed'({2'd0, step}));
    ns_lo = (ns < signed'({4'd0, min_scale})) ? signed'({4'd0, min_scale}) : ns;
    ns_cl = (ns_lo > signed'({4'd0, max_scale})) ? max_scale : ns_lo[SCALE_W-1:0];
    scale_diff = (ns_cl >= cur_scale) ? (ns_cl - cur_scale) : (cur_scale - ns_cl);
    force_lo    = (in_ch.scale_value < FMIN) ? FMIN : in_ch.scale_value;
    force_scale = (force_lo > FMAX) ? FMAX : force_lo;
    dim_cur = prod[DIM_W+14:15];
    h_new   = dim_round(dim_cur, nat_h);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ptr        <= '0;
      ring_sum   <= '0;
      avg_q      <= '0;
      cur_scale  <= RST_MAX_SCALE;
      cur_w      <= '0;
      cur_h      <= '0;
      change_cnt <= '0;
      changed    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // S_DONE reloads the register in the cycle it is collected
      if (out_ch.valid && out_ch.ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          changed <= 1'b0;
          if (accept) begin
            ft_q <= in_ch.frame_time;
            if (in_ch.opcode) begin
              cur_scale <= force_scale;
              state     <= S_DIM_W;
            end else if (enabled) begin
              state <= S_RING;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_RING: begin
          ring_sum <= sum_next;
          ptr      <= (ptr == PTR_LAST) ? '0 : ptr + 1'b1;
          state    <= S_AVG;
        end
        S_AVG: begin
          avg_q <= avg_est;
          state <= S_AVG_FIX;
        end
        S_AVG_FIX: begin
          // Estimate one short when the remainder reaches the depth
          if (avg_rem >= DEPTH_S) avg_q <= avg_q + 1'b1;
          state <= S_DEV;
        end
        S_DEV: begin
          dev_pos <= avg_gt;
          state   <= S_DIV_DEV;
        end
        S_DIV_DEV: begin
          if (div_stat.done) begin
            mag_q <= sat_mag;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= (mag_q > MAG_W'(threshold)) ? S_STEP : S_DONE;
        end
        S_STEP: begin
          if (scale_diff >= COMMIT_STEP) begin
            cur_scale <= ns_cl;
            state     <= S_DIM_W;
          end else begin
            state <= S_DONE;
          end
        end
        S_DIM_W: begin
          state <= S_DIM_H;
        end
        S_DIM_H: begin
          w_new <= dim_round(dim_cur, nat_w);
          state <= S_FIN;
        end
        S_FIN: begin
          if (w_new != cur_w || h_new != cur_h) begin
            cur_w      <= w_new;
            cur_h      <= h_new;
            change_cnt <= change_cnt + 1'b1;
            changed    <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // Load the result once the output register is free
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            o_w       <= cur_w;
            o_h       <= cur_h;
            o_scale   <= cur_scale;
            o_avg     <= avg_q;
            o_changed <= changed;
            o_cnt     <= change_cnt;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.render_width   = o_w;
  assign out_ch.render_height  = o_h;
  assign out_ch.scale          = o_scale;
  assign out_ch.avg_frame_time = o_avg;
  assign out_ch.size_changed   = o_changed;
  assign out_ch.change_count   = o_cnt;

  // Checks
  `DRSC_ASSERT_NEXT(a_busy_after_accept, accept, !in_ch.ready,
    "input still ready after a transfer")
  `DRSC_ASSERT_SAME(a_div_done_waited, div_stat.done,
    state == S_DIV_DEV, "divider finished with nobody waiting")
  `DRSC_ASSERT_SAME(a_div_no_restart, div_req.start, !div_stat.busy,
    "divider restarted while busy")
  `DRSC_ASSERT_NEXT(a_fin_after_dim, state == S_DIM_H, state == S_FIN,
    "height product not followed by size update")

endmodule

// File: bench/dynamic_resolution_scale_controller_tb.sv
`timescale 1ns / 1ps

module dynamic_resolution_scale_controller_tb;
  import drsc_pkg::*;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_FORCE  = 1'b1;

  localparam int unsigned HIST_DEPTH = 16;
  localparam longint FORCE_FLOOR = 8192;
  localparam longint FORCE_CEIL  = 65535;

  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 100;
  localparam int unsigned LONG_HOLD     = 300;

  typedef struct packed {
    logic               opcode;
    logic [TIME_W-1:0]  frame_time;
    logic [SCALE_W-1:0] scale_value;
  } frame_item_t;

  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [SCALE_W-1:0] scale;
    logic [TIME_W-1:0]  avg;
    logic               changed;
    logic [CNT_W-1:0]   count;
  } render_status_t;

  typedef struct packed {
    logic               enabled;
    logic [SCALE_W-1:0] min_scale;
    logic [SCALE_W-1:0] max_scale;
    logic [TIME_W-1:0]  target;
    logic [15:0]        speed;
    logic [15:0]        threshold;
    logic [NAT_W-1:0]   nat_w;
    logic [NAT_W-1:0]   nat_h;
  } ctrl_cfg_t;

  logic clk;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  drsc_in_if  in_ch();
  drsc_out_if out_ch();

  dynamic_resolution_scale_controller dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Queues between stimulus, driver and monitor
  frame_item_t    frames_to_send[$];
  render_status_t due_results[$];
  frame_item_t    offered;

  int unsigned send_gap_pct   = 0;
  int unsigned sink_stall_pct = 0;
  bit          sink_hold      = 1'b0;
  int unsigned mismatch_count = 0;

  // Shadow of the controller: settings and state
  ctrl_cfg_t          ctl;
  logic [TIME_W-1:0]  hist_ring [HIST_DEPTH];
  logic [3:0]         hist_ptr;
  logic [19:0]        hist_sum;
  logic [SCALE_W-1:0] cur_scale;
  logic [DIM_W-1:0]   cur_w;
  logic [DIM_W-1:0]   cur_h;
  logic [CNT_W-1:0]   resize_count;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_error(input string msg);
    mismatch_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic ctrl_cfg_t reset_config();
    ctrl_cfg_t c;
    c.enabled   = 1'b1;
    c.min_scale = RST_MIN_SCALE;
    c.max_scale = RST_MAX_SCALE;
    c.target    = RST_TARGET;
    c.speed     = RST_SPEED;
    c.threshold = RST_THRESHOLD;
    c.nat_w     = RST_NATIVE_W;
    c.nat_h     = RST_NATIVE_H;
    return c;
  endfunction

  // Render dimension: truncate, round up to even, floor of 64, cap at twice native
  function automatic logic [DIM_W-1:0] scaled_dim(input logic [NAT_W-1:0] native,
                                                  input logic [SCALE_W-1:0] s);
    longint d;
    d = (longint'(native) * longint'(s)) >>> 15;
    d = (d + 1) & ~longint'(1);
    if (d < longint'(MIN_DIM)) d = longint'(MIN_DIM);
    if (d > 2 * longint'(native)) d = 2 * longint'(native);
    return d[DIM_W-1:0];
  endfunction

  function automatic bit refresh_render_size();
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    w = scaled_dim(ctl.nat_w, cur_scale);
    h = scaled_dim(ctl.nat_h, cur_scale);
    if (w != cur_w || h != cur_h) begin
      cur_w = w;
      cur_h = h;
      resize_count = resize_count + 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Scale update for one accepted item; returns the status it should report
  function automatic render_status_t predict_scale_update(input frame_item_t it);
    render_status_t r;
    longint avg;
    longint tgt;
    longint dev;
    longint mag;
    longint step;
    longint nxt;
    longint diff;
    bit changed;
    changed = 1'b0;
    if (it.opcode == OP_FORCE) begin
      nxt = longint'(it.scale_value);
      if (nxt < FORCE_FLOOR) nxt = FORCE_FLOOR;
      if (nxt > FORCE_CEIL) nxt = FORCE_CEIL;
      cur_scale = nxt[SCALE_W-1:0];
      changed = refresh_render_size();
    end else if (ctl.enabled) begin
      hist_sum = hist_sum - 20'(hist_ring[hist_ptr]) + 20'(it.frame_time);
      hist_ring[hist_ptr] = it.frame_time;
      hist_ptr = hist_ptr + 4'd1;
      avg = longint'(hist_sum >> 4);
      tgt = (ctl.target == 0) ? longint'(1) : longint'(ctl.target);
      dev = ((avg - tgt) * 65536) / tgt;
      if (dev > longint'(DEV_LIMIT)) dev = longint'(DEV_LIMIT);
      if (dev < -longint'(DEV_LIMIT)) dev = -longint'(DEV_LIMIT);
      mag = (dev < 0) ? -dev : dev;
      if (mag > longint'(ctl.threshold)) begin
        step = (mag * longint'(ctl.speed)) >>> 17;
        nxt  = (dev > 0) ? longint'(cur_scale) - step : longint'(cur_scale) + step;
        if (nxt < longint'(ctl.min_scale)) nxt = longint'(ctl.min_scale);
        if (nxt > longint'(ctl.max_scale)) nxt = longint'(ctl.max_scale);
        diff = nxt - longint'(cur_scale);
        if (diff < 0) diff = -diff;
        if (diff >= longint'(COMMIT_STEP)) begin
          cur_scale = nxt[SCALE_W-1:0];
          changed = refresh_render_size();
        end
      end
    end
    r.width   = cur_w;
    r.height  = cur_h;
    r.scale   = cur_scale;
    r.avg     = hist_sum[19:4];
    r.changed = changed;
    r.count   = resize_count;
    return r;
  endfunction

  // Driver: offers queued items, predicts each one at its transfer
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) due_results.push_back(predict_scale_update(offered));
      if (!in_ch.valid || in_ch.ready) begin
        if (frames_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          offered = frames_to_send.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.opcode      <= offered.opcode;
          in_ch.frame_time  <= offered.frame_time;
          in_ch.scale_value <= offered.scale_value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_status();
    render_status_t want;
    if (due_results.size() == 0) begin
      report_error("result transfer with no item outstanding");
      return;
    end
    want = due_results.pop_front();
    if (out_ch.render_width !== want.width)
      report_error($sformatf("render_width %0d, expected %0d", out_ch.render_width, want.width));
    if (out_ch.render_height !== want.height)
      report_error($sformatf("render_height %0d, expected %0d",
                             out_ch.render_height, want.height));
    if (out_ch.scale !== want.scale)
      report_error($sformatf("scale %0d, expected %0d", out_ch.scale, want.scale));
    if (out_ch.avg_frame_time !== want.avg)
      report_error($sformatf("avg_frame_time %0d, expected %0d",
                             out_ch.avg_frame_time, want.avg));
    if (out_ch.size_changed !== want.changed)
      report_error($sformatf("size_changed %0b, expected %0b",
                             out_ch.size_changed, want.changed));
    if (out_ch.change_count !== want.count)
      report_error($sformatf("change_count %0d, expected %0d",
                             out_ch.change_count, want.count));
  endtask

  // Monitor: checks each result transfer, stalls at random or when held off
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_status();
      out_ch.ready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  // Writes every register; only called with the controller idle
  task automatic program_controller(input ctrl_cfg_t c);
    put_reg(CFG_ENABLED,   {15'd0, c.enabled});
    put_reg(CFG_MIN_SCALE, c.min_scale);
    put_reg(CFG_MAX_SCALE, c.max_scale);
    put_reg(CFG_TARGET,    c.target);
    put_reg(CFG_SPEED,     c.speed);
    put_reg(CFG_THRESHOLD, c.threshold);
    put_reg(CFG_NATIVE_W,  {2'b00, c.nat_w});
    put_reg(CFG_NATIVE_H,  {2'b00, c.nat_h});
    @(posedge clk);
    cfg_we <= 1'b0;
    ctl = c;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned sink_pct);
    @(posedge clk);
    send_gap_pct   <= send_pct;
    sink_stall_pct <= sink_pct;
  endtask

  task automatic send_frame(input logic op, input logic [TIME_W-1:0] ft,
                            input logic [SCALE_W-1:0] sv);
    frame_item_t it;
    it.opcode      = op;
    it.frame_time  = ft;
    it.scale_value = sv;
    frames_to_send.push_back(it);
  endtask

  // Waits until every queued item has been transferred and answered
  task automatic wait_drained();
    do @(negedge clk);
    while (frames_to_send.size() != 0 || in_ch.valid || due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Frame times mostly around the target so the average hovers near it
  function automatic frame_item_t random_item();
    frame_item_t it;
    int unsigned t;
    it.opcode      = ($urandom_range(5) == 0) ? OP_FORCE : OP_RECORD;
    it.scale_value = 16'($urandom);
    if ($urandom_range(7) == 0) it.scale_value = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    t = (ctl.target == 0) ? 1 : ctl.target;
    case ($urandom_range(9))
      6, 7: it.frame_time = 16'($urandom);
      8: it.frame_time = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      9: it.frame_time = 16'($urandom_range(31));
      default: begin
        t = t * $urandom_range(30, 300) / 100;
        it.frame_time = (t > 65535) ? 16'hFFFF : 16'(t);
      end
    endcase
    return it;
  endfunction

  function automatic ctrl_cfg_t random_config();
    ctrl_cfg_t c;
    c.enabled   = ($urandom_range(7) != 0);
    c.min_scale = 16'($urandom_range(4096, 32768));
    c.max_scale = 16'($urandom_range(c.min_scale, 65535));
    c.target    = 16'($urandom_range(16, 1600));
    c.speed     = 16'($urandom);
    c.threshold = 16'($urandom_range(0, 16384));
    c.nat_w     = 14'($urandom_range(1, 8192));
    c.nat_h     = 14'($urandom_range(1, 8192));
    if ($urandom_range(5) == 0) c.min_scale = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    if ($urandom_range(5) == 0) c.max_scale = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    if ($urandom_range(7) == 0) c.target = $urandom_range(1) ? 16'hFFFF : 16'h0010;
    if ($urandom_range(5) == 0) c.speed = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    if ($urandom_range(7) == 0) c.threshold = 16'hFFFF;
    if ($urandom_range(7) == 0) c.nat_w = $urandom_range(1) ? 14'h3FFF : 14'd0;
    if ($urandom_range(7) == 0) c.nat_h = $urandom_range(1) ? 14'h3FFF : 14'd1;
    return c;
  endfunction

  initial begin : stimulus
    ctrl_cfg_t c;
    cfg_we = 1'b0;
    cfg_index = CFG_ENABLED;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_RECORD;
    in_ch.frame_time = '0;
    in_ch.scale_value = '0;
    out_ch.ready = 1'b0;
    ctl = reset_config();
    foreach (hist_ring[i]) hist_ring[i] = '0;
    hist_ptr = '0;
    hist_sum = '0;
    cur_scale = RST_MAX_SCALE;
    cur_w = '0;
    cur_h = '0;
    resize_count = '0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: a short frame at maximum scale, forced scales, then long and mixed frames
    send_frame(OP_RECORD, 16'h0000, 16'hFFFF);
    send_frame(OP_FORCE, 16'h0000, 16'h0000);
    send_frame(OP_FORCE, 16'hFFFF, 16'hFFFF);
    send_frame(OP_FORCE, 16'h0000, 16'd8191);
    send_frame(OP_FORCE, 16'h0000, 16'h8000);
    repeat (4) send_frame(OP_RECORD, 16'hFFFF, 16'h5555);
    send_frame(OP_RECORD, 16'd267, 16'hAAAA);
    send_frame(OP_FORCE, 16'h5555, 16'hAAAA);
    send_frame(OP_FORCE, 16'hAAAA, 16'h5555);
    send_frame(OP_RECORD, 16'h5555, 16'h0000);
    send_frame(OP_RECORD, 16'hAAAA, 16'h0000);
    wait_drained();

    // Disabled: frame times ignored, forced scale still applies
    c = reset_config();
    c.enabled = 1'b0;
    program_controller(c);
    send_frame(OP_RECORD, 16'hFFFF, 16'h0000);
    send_frame(OP_FORCE, 16'h0000, 16'd20000);
    send_frame(OP_RECORD, 16'h0000, 16'hFFFF);
    wait_drained();

    // Zero target, inverted bounds, full gain, no threshold, tallest display
    c = reset_config();
    c.target = 16'd0;
    c.min_scale = 16'd40000;
    c.max_scale = 16'd20000;
    c.speed = 16'hFFFF;
    c.threshold = 16'h0000;
    c.nat_w = 14'd8192;
    c.nat_h = 14'h3FFF;
    program_controller(c);
    send_frame(OP_RECORD, 16'h0000, 16'h0000);
    send_frame(OP_RECORD, 16'd100, 16'h0000);
    send_frame(OP_FORCE, 16'h0000, 16'hFFFF);
    wait_drained();

    // Zero native width: the cap of twice native wins over the floor
    c = reset_config();
    c.nat_w = 14'd0;
    c.nat_h = 14'd1;
    program_controller(c);
    send_frame(OP_FORCE, 16'h0000, 16'hFFFF);
    send_frame(OP_FORCE, 16'h0000, 16'd8192);
    wait_drained();

    // Widest bounds, largest target and threshold, zero gain
    c = reset_config();
    c.min_scale = 16'h0000;
    c.max_scale = 16'hFFFF;
    c.target = 16'hFFFF;
    c.speed = 16'h0000;
    c.threshold = 16'hFFFF;
    c.nat_w = 14'd1;
    c.nat_h = 14'd8192;
    program_controller(c);
    send_frame(OP_RECORD, 16'h0000, 16'h0000);
    send_frame(OP_RECORD, 16'hFFFF, 16'h0000);
    send_frame(OP_FORCE, 16'hFFFF, 16'hFFFF);
    wait_drained();

    // Random phases under varied settings and idling
    for (int ph = 0; ph < 8; ph++) begin
      c = (ph == 0 || ph == 4) ? reset_config() : random_config();
      program_controller(c);
      case (ph % 4)
        0: set_idling(0, 0);
        1: set_idling(45, 0);
        2: set_idling(0, 45);
        default: set_idling(7, 7);
      endcase
      // hold the result side off so the block backs up onto its input
      if (ph == 4) begin
        fork
          begin
            @(posedge clk);
            sink_hold <= 1'b1;
            repeat (LONG_HOLD) @(posedge clk);
            sink_hold <= 1'b0;
          end
        join_none
      end
      repeat (45) frames_to_send.push_back(random_item());
      wait_drained();
      repeat (45) frames_to_send.push_back(random_item());
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
